// ----- design/ldl_pkg.sv -----
// shared types, widths and constants of the laplace double-layer kernel unit
// no dependencies
package ldl_pkg;

	localparam int COORD_BITS = 24;
	localparam int NORM_BITS  = 18;
	localparam int FAR_BITS   = 24;
	localparam int D_W        = FAR_BITS + 1;
	localparam int X_W        = (COORD_BITS + 1 > FAR_BITS + 2) ? COORD_BITS + 1 : FAR_BITS + 2;
	localparam int SQ_W       = 2 * D_W;
	localparam int PR_W       = D_W + NORM_BITS;
	localparam int P_W        = PR_W + 2;
	localparam int PA_W       = PR_W;
	localparam int K_W        = 6;
	localparam int E_W        = 8;
	localparam int EP_W       = 6;
	localparam int U_W        = 62;
	localparam int U_TOP      = U_W - 2;
	localparam int RT_W       = 31;
	localparam int REM_W      = U_W + 1;
	localparam int UH_W       = U_W - 30;
	localparam int M_W        = UH_W + RT_W;
	localparam int H_W        = M_W - 32;
	localparam int C_W        = 32;
	localparam int W_W        = 63;
	localparam int QB         = 35;
	localparam int E_MAX      = 54;
	localparam int SHV_W      = PA_W + E_MAX;
	localparam int PS_W       = 5;
	localparam int OUT_W      = 32;
	localparam int FQ_DEPTH   = 4;
	localparam int FQ_AW      = 2;

	localparam logic [C_W-1:0] FOUR_PI_Q28 = 32'hC90FDAA2;

	typedef enum logic [1:0] {
		KIND_CALC = 2'd0,
		KIND_SING = 2'd1,
		KIND_ZERO = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic signed [D_W-1:0]       dx;
		logic signed [D_W-1:0]       dy;
		logic signed [D_W-1:0]       dz;
		logic signed [NORM_BITS-1:0] nx;
		logic signed [NORM_BITS-1:0] ny;
		logic signed [NORM_BITS-1:0] nz;
	} pair_t;

	typedef struct packed {
		logic                  vld;
		kind_t                 kind;
		logic                  neg;
		logic                  ovf;
		logic signed [E_W-1:0] e;
		logic [PA_W-1:0]       pa;
	} tag_t;

endpackage

// ----- design/ldl_front.sv -----
// front stage: takes an item, forms the point difference and classifies the pair
// depends on ldl_pkg
module ldl_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_x,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_y,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_z,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_x,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_y,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_z,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_x,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_y,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_z,
	output logic                                 wr_valid,
	input  logic                                 wr_ready,
	output ldl_pkg::pair_t                       wr_data
);
	import ldl_pkg::*;

	localparam logic signed [X_W-1:0] FAR_POS = X_W'(2**FAR_BITS);
	localparam logic signed [X_W-1:0] FAR_NEG = -FAR_POS;

	logic signed [X_W-1:0] dxw, dyw, dzw;
	logic                  far, sing;
	pair_t                 pr_d;
	logic                  v_s1;
	pair_t                 pr_s1;

	always_comb begin
		dxw  = X_W'(test_x) - X_W'(trial_x);
		dyw  = X_W'(test_y) - X_W'(trial_y);
		dzw  = X_W'(test_z) - X_W'(trial_z);
		far  = (dxw >= FAR_POS) || (dxw <= FAR_NEG) ||
		       (dyw >= FAR_POS) || (dyw <= FAR_NEG) ||
		       (dzw >= FAR_POS) || (dzw <= FAR_NEG);
		sing = (dxw == '0) && (dyw == '0) && (dzw == '0);
		if (sing) begin
			pr_d.kind = KIND_SING;
		end else if (far) begin
			pr_d.kind = KIND_ZERO;
		end else begin
			pr_d.kind = KIND_CALC;
		end
		pr_d.dx = dxw[D_W-1:0];
		pr_d.dy = dyw[D_W-1:0];
		pr_d.dz = dzw[D_W-1:0];
		pr_d.nx = normal_x;
		pr_d.ny = normal_y;
		pr_d.nz = normal_z;
	end

	assign in_ready = !v_s1 || wr_ready;
	assign wr_valid = v_s1;
	assign wr_data  = pr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pr_s1 <= pr_d;
		end
	end

endmodule

// ----- design/ldl_fifo.sv -----
// short queue of classified pairs between front and back
// depends on ldl_pkg
module ldl_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  ldl_pkg::pair_t wr_data,
	output logic           rd_valid,
	input  logic           rd_en,
	output ldl_pkg::pair_t rd_data
);
	import ldl_pkg::*;

	pair_t            mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wp_q, rp_q;
	logic [FQ_AW:0]   cnt_q;
	logic             push, pop;

	assign wr_ready = cnt_q != (FQ_AW+1)'(FQ_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ----- design/ldl_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on ldl_pkg
module ldl_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  ldl_pkg::tag_t              in_tag,
	input  logic [ldl_pkg::U_W-1:0]    in_u,
	output ldl_pkg::tag_t              out_tag,
	output logic [ldl_pkg::RT_W-1:0]   out_root,
	output logic [ldl_pkg::UH_W-1:0]   out_uh
);
	import ldl_pkg::*;

	tag_t              tag_q  [RT_W+1];
	logic [REM_W-1:0]  rem_q  [RT_W+1];
	logic [RT_W-1:0]   root_q [RT_W+1];
	logic [UH_W-1:0]   uh_q   [RT_W+1];

	assign tag_q[0]  = in_tag;
	assign rem_q[0]  = REM_W'(in_u);
	assign root_q[0] = '0;
	assign uh_q[0]   = in_u[U_W-1:U_W-UH_W];

	for (genvar g = 0; g < RT_W; g++) begin : g_stage
		localparam int B = RT_W - 1 - g;
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			trial = ((REM_W'(root_q[g]) << 1) | (REM_W'(1) << B)) << B;
			ge    = rem_q[g] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_q[g+1].vld <= 1'b0;
			end else if (en) begin
				tag_q[g+1] <= tag_q[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1]  <= ge ? rem_q[g] - trial : rem_q[g];
				root_q[g+1] <= ge ? (root_q[g] | (RT_W'(1) << B)) : root_q[g];
				uh_q[g+1]   <= uh_q[g];
			end
		end
	end

	assign out_tag  = tag_q[RT_W];
	assign out_root = root_q[RT_W];
	assign out_uh   = uh_q[RT_W];

endmodule

// ----- design/ldl_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on ldl_pkg
module ldl_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ldl_pkg::tag_t            in_tag,
	input  logic [ldl_pkg::W_W-1:0]  in_r,
	input  logic [ldl_pkg::W_W-1:0]  in_w,
	output ldl_pkg::tag_t            out_tag,
	output logic [ldl_pkg::QB-1:0]   out_q
);
	import ldl_pkg::*;

	tag_t           tag_q [QB+1];
	logic [W_W-1:0] r_q   [QB+1];
	logic [W_W-1:0] w_q   [QB+1];
	logic [QB-1:0]  q_q   [QB+1];

	assign tag_q[0] = in_tag;
	assign r_q[0]   = in_r;
	assign w_q[0]   = in_w;
	assign q_q[0]   = '0;

	for (genvar g = 0; g < QB; g++) begin : g_stage
		logic [W_W:0] r2, df;
		logic         ge;

		always_comb begin
			r2 = {r_q[g], 1'b0};
			ge = r2 >= {1'b0, w_q[g]};
			df = r2 - {1'b0, w_q[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_q[g+1].vld <= 1'b0;
			end else if (en) begin
				tag_q[g+1] <= tag_q[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[g+1] <= ge ? df[W_W-1:0] : r2[W_W-1:0];
				w_q[g+1] <= w_q[g];
				q_q[g+1] <= {q_q[g][QB-2:0], ge};
			end
		end
	end

	assign out_tag = tag_q[QB];
	assign out_q   = q_q[QB];

endmodule

// ----- design/ldl_back.sv -----
// back pipeline: products, normalize, square root, scale, divide, round, saturate
// depends on ldl_pkg, ldl_sqrt, ldl_div
module ldl_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_valid,
	output logic                              rd_en,
	input  ldl_pkg::pair_t                    rd_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ldl_pkg::OUT_W-1:0]  potential,
	output logic                              singular,
	output logic                              saturated
);
	import ldl_pkg::*;

	localparam logic [QB-1:0] LIM_POS = QB'(64'h7FFFFFFF);
	localparam logic [QB-1:0] LIM_NEG = QB'(64'h80000000);

	logic en;

	logic signed [SQ_W-1:0] sq0, sq1, sq2;
	logic signed [PR_W-1:0] pn0, pn1, pn2;
	tag_t                   t1_d;
	tag_t                   tag_s1;
	logic [SQ_W-1:0]        sq_s1 [3];
	logic signed [PR_W-1:0] pn_s1 [3];

	tag_t                   tag_s2;
	logic [SQ_W-1:0]        s_s2;
	logic signed [P_W-1:0]  p_s2;

	logic [K_W-1:0]         top, kodd, k_d;
	logic                   pzero, pneg;
	logic signed [P_W-1:0]  pabs;
	tag_t                   t3_d;
	tag_t                   tag_s3;
	logic [SQ_W-1:0]        s_s3;
	logic [K_W-1:0]         k_s3;

	logic [E_W-1:0]         half;
	tag_t                   t4_d;
	tag_t                   tag_s4;
	logic [U_W-1:0]         u_s4;

	tag_t                   sq_tag;
	logic [RT_W-1:0]        sq_root;
	logic [UH_W-1:0]        sq_uh;

	logic [M_W-1:0]         m_d;
	tag_t                   tag_s5;
	logic [H_W-1:0]         h_s5;

	tag_t                   tag_s6;
	logic [W_W-1:0]         w_s6;

	logic [EP_W-1:0]        epos;
	logic [SHV_W-1:0]       shv;
	logic [W_W-1:0]         r0;
	tag_t                   t7_d;
	tag_t                   tag_s7;
	logic [W_W-1:0]         r_s7, w_s7;

	tag_t                   dv_tag;
	logic [QB-1:0]          dv_q;

	logic [PS_W-1:0]        ps;
	logic [QB-1:0]          qs, lim, mag, msel, nmag;
	logic [QB:0]            magw;
	logic                   sat;
	logic signed [OUT_W-1:0] pot_d;
	logic                   sing_d, sat_d;
	logic                   ov_q;
	logic signed [OUT_W-1:0] pot_q;
	logic                   sing_q, sat_q;

	assign en    = !ov_q || out_ready;
	assign rd_en = en;

	// products
	always_comb begin
		sq0 = rd_data.dx * rd_data.dx;
		sq1 = rd_data.dy * rd_data.dy;
		sq2 = rd_data.dz * rd_data.dz;
		pn0 = rd_data.dx * rd_data.nx;
		pn1 = rd_data.dy * rd_data.ny;
		pn2 = rd_data.dz * rd_data.nz;
		t1_d      = '0;
		t1_d.vld  = rd_valid;
		t1_d.kind = rd_data.kind;
	end

	// normalize and sign
	always_comb begin
		top = '0;
		for (int b = 0; b < SQ_W; b++) begin
			if (s_s2[b]) begin
				top = K_W'(b);
			end
		end
		kodd  = K_W'(U_TOP) - top;
		k_d   = kodd + K_W'(kodd[0]);
		pzero = p_s2 == '0;
		pneg  = p_s2[P_W-1];
		pabs  = pneg ? -p_s2 : p_s2;
		t3_d      = tag_s2;
		t3_d.neg  = !pneg && !pzero;
		t3_d.pa   = pabs[PA_W-1:0];
		t3_d.kind = (tag_s2.kind == KIND_CALC && pzero) ? KIND_ZERO : tag_s2.kind;
	end

	always_comb begin
		half   = E_W'(k_s3[K_W-1:1]);
		t4_d   = tag_s3;
		t4_d.e = $signed(E_W'(half * E_W'(3)) - E_W'(QB + 1));
	end

	assign m_d = M_W'(sq_uh) * M_W'(sq_root);

	// align the dividend
	always_comb begin
		epos     = tag_s6.e[E_W-1] ? '0 : tag_s6.e[EP_W-1:0];
		shv      = SHV_W'(tag_s6.pa) << epos;
		r0       = shv[W_W-1:0];
		t7_d     = tag_s6;
		t7_d.ovf = (|shv[SHV_W-1:W_W]) || (r0 >= w_s6);
	end

	// round and saturate
	always_comb begin
		ps     = dv_tag.e[E_W-1] ? PS_W'(-dv_tag.e) : '0;
		qs     = dv_q >> ps;
		magw   = {1'b0, qs} + (QB+1)'(1);
		mag    = magw[QB:1];
		lim    = dv_tag.neg ? LIM_NEG : LIM_POS;
		sat    = dv_tag.ovf || (mag > lim);
		msel   = sat ? lim : mag;
		nmag   = QB'(0) - msel;
		pot_d  = dv_tag.neg ? nmag[OUT_W-1:0] : msel[OUT_W-1:0];
		sat_d  = sat;
		sing_d = 1'b0;
		unique case (dv_tag.kind)
			KIND_CALC: begin
			end
			KIND_SING: begin
				pot_d  = '0;
				sat_d  = 1'b0;
				sing_d = 1'b1;
			end
			default: begin
				pot_d = '0;
				sat_d = 1'b0;
			end
		endcase
	end

	ldl_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_tag   (tag_s4),
		.in_u     (u_s4),
		.out_tag  (sq_tag),
		.out_root (sq_root),
		.out_uh   (sq_uh)
	);

	ldl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (tag_s7),
		.in_r    (r_s7),
		.in_w    (w_s7),
		.out_tag (dv_tag),
		.out_q   (dv_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1.vld <= 1'b0;
			tag_s2.vld <= 1'b0;
			tag_s3.vld <= 1'b0;
			tag_s4.vld <= 1'b0;
			tag_s5.vld <= 1'b0;
			tag_s6.vld <= 1'b0;
			tag_s7.vld <= 1'b0;
			ov_q       <= 1'b0;
		end else if (en) begin
			tag_s1 <= t1_d;
			tag_s2 <= tag_s1;
			tag_s3 <= t3_d;
			tag_s4 <= t4_d;
			tag_s5 <= sq_tag;
			tag_s6 <= tag_s5;
			tag_s7 <= t7_d;
			ov_q   <= dv_tag.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1[0] <= sq0;
			sq_s1[1] <= sq1;
			sq_s1[2] <= sq2;
			pn_s1[0] <= pn0;
			pn_s1[1] <= pn1;
			pn_s1[2] <= pn2;
			s_s2     <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			p_s2     <= P_W'(pn_s1[0]) + P_W'(pn_s1[1]) + P_W'(pn_s1[2]);
			s_s3     <= s_s2;
			k_s3     <= k_d;
			u_s4     <= U_W'(s_s3) << k_s3;
			h_s5     <= m_d[M_W-1:M_W-H_W];
			w_s6     <= W_W'(h_s5) * W_W'(FOUR_PI_Q28);
			r_s7     <= r0;
			w_s7     <= w_s6;
			pot_q    <= pot_d;
			sing_q   <= sing_d;
			sat_q    <= sat_d;
		end
	end

	assign out_valid = ov_q;
	assign potential = pot_q;
	assign singular  = sing_q;
	assign saturated = sat_q;

endmodule

// ----- design/laplace_double_layer_kernel_3d_unit.sv -----
// top level of the laplace double-layer kernel unit
// depends on ldl_pkg, ldl_front, ldl_fifo, ldl_back
//
// Evaluates -(d.n)/(4*pi*|d|^3) for one test/trial point pair and trial normal.
// Input channel: in_valid/in_ready with test, trial (Q8.16) and normal (Q1.16).
// Output channel: out_valid/out_ready with potential (Q16.16), singular, saturated.
// Throughput: one pair per cycle, sustained while out_ready stays high.
// Most of the pipeline depth lies in the 31-stage square root and the
// 35-stage divider.
// The front stage takes an item into a 4-entry queue; the back pipeline
// advances as a whole and halts only while a result waits at the output, so
// the front keeps taking items until the queue fills.
// Coincident points give zero with singular set; far pairs and a zero dot
// product give zero; out-of-range values clamp with saturated set.
// Reset empties the queue and all pipeline stages; no results are pending.
module laplace_double_layer_kernel_3d_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_x,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_y,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_z,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_x,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_y,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_z,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_x,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_y,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [ldl_pkg::OUT_W-1:0]      potential,
	output logic                                  singular,
	output logic                                  saturated
);
	import ldl_pkg::*;

	logic  wr_valid, wr_ready, rd_valid, rd_en;
	pair_t wr_data, rd_data;

	ldl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.test_x   (test_x),
		.test_y   (test_y),
		.test_z   (test_z),
		.trial_x  (trial_x),
		.trial_y  (trial_y),
		.trial_z  (trial_z),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data)
	);

	ldl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data),
		.rd_valid (rd_valid),
		.rd_en    (rd_en),
		.rd_data  (rd_data)
	);

	ldl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (rd_valid),
		.rd_en     (rd_en),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.potential (potential),
		.singular  (singular),
		.saturated (saturated)
	);

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> potential == '0 && !saturated)
		else $error("singular result not zero");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> potential == 32'sh7FFFFFFF || potential == 32'sh80000000)
		else $error("saturated result not clamped");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(singular && saturated))
		else $error("singular and saturated both set");

endmodule

// ----- test/ldl_checker.sv -----
// checker of the laplace double-layer kernel unit: predicts each kernel value and compares
// depends on ldl_pkg; watches both channels of the unit
module ldl_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_x,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_y,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] test_z,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_x,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_y,
	input  logic signed [ldl_pkg::COORD_BITS-1:0] trial_z,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_x,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_y,
	input  logic signed [ldl_pkg::NORM_BITS-1:0]  normal_z,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [ldl_pkg::OUT_W-1:0]      potential,
	input  logic                                  singular,
	input  logic                                  saturated,
	output int                                    errors,
	output int                                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] pot;
		logic        sing;
		logic        sat;
	} kernel_t;

	localparam logic [63:0] FOUR_PI = 64'(ldl_pkg::FOUR_PI_Q28);

	kernel_t expected_q[$];

	function automatic kernel_t kernel_value(longint t0, longint t1, longint t2,
			longint s0, longint s1, longint s2, longint n0, longint n1, longint n2);
		kernel_t res;
		longint d[3];
		longint nv[3];
		longint p;
		bit [63:0] sq, u, rt, op, one, m, w, r, q, mag, lim;
		int top, k, sh;
		bit far, neg, sat;
		res = '0;
		d[0] = t0 - s0; d[1] = t1 - s1; d[2] = t2 - s2;
		nv[0] = n0; nv[1] = n1; nv[2] = n2;
		far = 0;
		sq = 0;
		p = 0;
		for (int i = 0; i < 3; i++) begin
			if (d[i] >= (64'sd1 <<< 24) || d[i] <= -(64'sd1 <<< 24))
				far = 1;
			sq += 64'(d[i] * d[i]);
			p += d[i] * nv[i];
		end
		if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
			res.sing = 1;
			return res;
		end
		if (far || p == 0)
			return res;
		top = 63;
		while (sq[top] == 0)
			top--;
		k = 60 - top;
		if (k % 2)
			k++;
		u = sq << k;
		op = u;
		rt = 0;
		one = 64'd1 << 62;
		while (one > op)
			one >>= 2;
		while (one != 0) begin
			if (op >= rt + one) begin
				op -= rt + one;
				rt = (rt >> 1) + one;
			end else begin
				rt >>= 1;
			end
			one >>= 2;
		end
		m = (u >> 30) * rt;
		w = (m >> 32) * FOUR_PI;
		neg = p > 0;
		r = (p < 0) ? 64'(-p) : 64'(p);
		q = 0;
		sat = 0;
		sh = (3 * k) / 2 - 1;
		for (int j = 0; j < sh; j++) begin
			r <<= 1;
			q <<= 1;
			if (r >= w) begin
				r -= w;
				q |= 1;
			end
			if (q >= (64'd1 << 34)) begin
				sat = 1;
				break;
			end
		end
		mag = (q + 1) >> 1;
		lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
		if (sat || mag > lim) begin
			mag = lim;
			res.sat = 1;
		end
		res.pot = neg ? 32'(64'd0 - mag) : 32'(mag);
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		kernel_t e;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_q.push_back(kernel_value(test_x, test_y, test_z, trial_x, trial_y,
					trial_z, normal_x, normal_y, normal_z));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected item: potential %h", potential);
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.pot !== potential || e.sing !== singular || e.sat !== saturated) begin
						if (errors < 10)
							$display("mismatch: exp %h/%b/%b got %h/%b/%b", e.pot, e.sing,
								e.sat, potential, singular, saturated);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

// ----- test/testbench.sv -----
// top of the laplace double-layer kernel unit test: clock, reset, stimulus and verdict
// depends on ldl_pkg, laplace_double_layer_kernel_3d_unit and ldl_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = ldl_pkg::COORD_BITS;
	localparam int NW = ldl_pkg::NORM_BITS;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [CW-1:0] test_x = 0, test_y = 0, test_z = 0;
	logic signed [CW-1:0] trial_x = 0, trial_y = 0, trial_z = 0;
	logic signed [NW-1:0] normal_x = 0, normal_y = 0, normal_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [ldl_pkg::OUT_W-1:0] potential;
	logic singular, saturated;
	int errors, pending;
	int cycles = 0;
	int burst_left = 0;

	always #1 clk = ~clk;

	laplace_double_layer_kernel_3d_unit DUT (.*);
	ldl_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("[laplace_double_layer_kernel_3d_unit] ERROR");
			$finish;
		end
	end

	// receiver stalls: long ready stretches, then bursts of random stalls
	always @(posedge clk) begin
		int mode;
		mode = (cycles / 300) % 3;
		if (mode == 0)
			out_ready <= 1;
		else if (mode == 1)
			out_ready <= ($urandom_range(0, 3) != 0);
		else
			out_ready <= ($urandom_range(0, 2) == 0);
	end

	task automatic send_pair(input logic [CW-1:0] tx, ty, tz, sx, sy, sz,
			input logic [NW-1:0] nx, ny, nz);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1;
		test_x <= tx; test_y <= ty; test_z <= tz;
		trial_x <= sx; trial_y <= sy; trial_z <= sz;
		normal_x <= nx; normal_y <= ny; normal_z <= nz;
		forever begin
			@(negedge clk);
			if (in_ready)
				break;
		end
		@(posedge clk);
	endtask

	task automatic random_pair();
		logic [CW-1:0] tx, ty, tz, ox, oy, oz;
		int sc;
		tx = CW'($urandom); ty = CW'($urandom); tz = CW'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			ox = CW'($urandom); oy = CW'($urandom); oz = CW'($urandom);
		end else begin
			sc = $urandom_range(0, 23);
			ox = CW'($signed($urandom) >>> (31 - sc));
			oy = CW'($signed($urandom) >>> (31 - sc));
			oz = CW'($signed($urandom) >>> (31 - sc));
		end
		send_pair(tx, ty, tz, tx - ox, ty - oy, tz - oz, NW'($urandom), NW'($urandom),
			NW'($urandom));
	endtask

	localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [NW-1:0] NONE = 18'h10000;
	localparam logic [NW-1:0] NMAX = {1'b0, {(NW-1){1'b1}}};
	localparam logic [NW-1:0] NMIN = {1'b1, {(NW-1){1'b0}}};

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// coincident points, zero dot product, overflow both signs
		send_pair(5, 6, 7, 5, 6, 7, NONE, 0, 0);
		send_pair(CMAX, CMIN, 0, CMAX, CMIN, 0, NMAX, NMIN, NMAX);
		send_pair(65536, 0, 0, 0, 0, 0, 0, NONE, 0);
		send_pair(CMAX, 0, 0, CMIN, 0, 0, NONE, 0, 0);
		send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, NMIN, NMIN, NMIN);
		send_pair(1, 0, 0, 0, 0, 0, NONE, 0, 0);
		send_pair(0, 0, 0, 1, 0, 0, NONE, 0, 0);
		send_pair(0, 1, 1, 0, 0, 0, NMIN, NMIN, NMAX);
		send_pair(65536, 0, 0, 0, 0, 0, NONE, 0, 0);
		send_pair(0, 0, 65536, 0, 0, 0, 0, 0, NMIN);
		send_pair(CMAX, CMAX, CMAX, 0, 0, 0, NMAX, NMAX, NMAX);
		send_pair(0, 0, 0, CMAX, CMAX, CMAX, NMAX, NMAX, NMAX);
		send_pair(24'h7FFFFF, 24'h400000, 0, 24'h000001, 24'hC00001, 0, NONE, NONE, 0);
		send_pair(300, 200, 100, 0, 0, 0, NMAX, NMIN, 0);
		send_pair(CMIN, 0, 0, 24'h800001, 0, 0, NMIN, 0, 0);
		for (int i = 0; i < 650; i++) begin
			random_pair();
			if (i == 300) begin
				in_valid <= 0;
				burst_left = 0;
				do
					@(posedge clk);
				while (pending != 0);
			end
		end
		in_valid <= 0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[laplace_double_layer_kernel_3d_unit] OK");
		else
			$display("[laplace_double_layer_kernel_3d_unit] ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
design/ldl_pkg.sv
design/ldl_front.sv
design/ldl_fifo.sv
design/ldl_sqrt.sv
design/ldl_div.sv
design/ldl_back.sv
design/laplace_double_layer_kernel_3d_unit.sv
test/ldl_checker.sv
test/testbench.sv
